FILE: sv/hex_serial_frame_filter_macros.svh
// Assertion macros shared by the frame filter checkers.
`ifndef HEX_SERIAL_FRAME_FILTER_MACROS_SVH
`define HEX_SERIAL_FRAME_FILTER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define HSFF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame filter check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define HSFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame filter check failed");

`endif

FILE: sv/hsff_pkg.sv
// Shared types and constants of the hex serial frame filter.
package hsff_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int MAX_DIGITS_DEF = 8;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;
    localparam int ADDR_W     = 3;

    // input word layout
    localparam int IU_MODE  = 0;
    localparam int IU_START = 1;

    // output word layout
    localparam int OD_ACC    = 0;
    localparam int OD_SER_LO = 1;
    localparam int OD_SER_HI = 32;
    localparam int OD_IDX_LO = 33;
    localparam int OD_IDX_HI = 36;
    localparam int OD_MSR_LO = 37;
    localparam int OD_MSR_HI = 68;
    localparam int OD_ERR    = 69;

    localparam logic [ADDR_W-1:0] ADDR_OWN_SERIAL = 3'd0;

    localparam logic [1:0] SRC_BELL  = 2'd0;
    localparam logic [1:0] SRC_DOOR  = 2'd1;
    localparam logic [1:0] SRC_OTHER = 2'd2;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_ENTRY = 1'b1;

    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] LETTER_OFS = 8'd55;

    // search token walking the list cells
    typedef struct packed {
        logic       valid;
        logic       done;
        logic       hit;
        logic [3:0] idx;
    } t_token;

endpackage

FILE: sv/hsff_cell.sv
// One allow-list slot: holds an entry and passes the search token on.
module hsff_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [31:0]    i_wr_data,
    input  logic [31:0]    i_key,
    input  hsff_pkg::t_token i_tok,
    output hsff_pkg::t_token o_tok
);
    import hsff_pkg::*;

    logic [31:0] r_entry;
    t_token      r_tok;
    t_token      n_tok;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.done) begin
            if (r_entry == 32'd0) begin
                n_tok.done = 1'b1;
            end else if (r_entry == i_key) begin
                n_tok.done = 1'b1;
                n_tok.hit  = 1'b1;
                n_tok.idx  = 4'(CELL_IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= 32'd0;
            r_tok   <= '0;
        end else begin
            if (i_wr_en) begin
                r_entry <= i_wr_data;
            end
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: sv/hex_serial_frame_filter.sv
// Top level: hex serial frame parser with allow-list search chain.
//
// channel  | direction | signals                     | contents
// s_axis   | in        | tvalid tready tdata tuser   | message byte or list entry
// m_axis   | out       | tvalid tready tdata tuser   | frame verdict on 'T'
// apb      | in        | psel penable pwrite paddr.. | own_serial at address 0
//
// Ordinary bytes and entry writes are taken in the idle state, which they keep.
// A closing 'T' of a bell, other or bad frame moves to the send state; of a door
// frame it first waits in search for the token to walk the row of list cells.
// Reset clears the list, the parser and own_serial.
// Input is taken while a verdict waits on m_axis; a new verdict waits for it.
module hex_serial_frame_filter #(
    parameter int LIST_DEPTH = hsff_pkg::LIST_DEPTH_DEF,
    parameter int MAX_DIGITS = hsff_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_byte[7:0], entry_index[11:8], entry_value[43:12], zero pad
    input  logic [hsff_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0], frame_start[1]
    input  logic [hsff_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accepted[0], parsed_serial[32:1], matched_index[36:33],
    // matched_serial[68:37], format_error[69], zero pad
    output logic [hsff_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // source_kind[1:0]
    output logic [hsff_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsff_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import hsff_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_SEND   = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [31:0]      r_own;
    logic [1:0]       r_pos,  n_pos;
    logic [1:0]       r_src,  n_src;
    logic [31:0]      r_acc,  n_acc;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_err,  n_err;
    logic             r_done, n_done;

    logic             r_res_acc, n_res_acc;
    logic [3:0]       r_res_idx, n_res_idx;
    logic [31:0]      r_res_ser, n_res_ser;

    logic                  r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data,  n_m_data;
    logic [OUT_USER_W-1:0] r_m_user,  n_m_user;

    logic        w_in_acc;
    logic        w_mode;
    logic        w_start;
    logic [7:0]  w_byte;
    logic [3:0]  w_eidx;
    logic [31:0] w_eval;
    logic        w_is_hex;
    logic [3:0]  w_nib;
    logic        w_launch;
    logic        w_load_out;

    t_token w_tok [LIST_DEPTH+1];

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_mode   = s_axis_tuser[IU_MODE];
    assign w_start  = s_axis_tuser[IU_START];
    assign w_byte   = s_axis_tdata[7:0];
    assign w_eidx   = s_axis_tdata[11:8];
    assign w_eval   = s_axis_tdata[43:12];

    assign s_axis_tready = (r_state == S_IDLE);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_OWN_SERIAL) ? r_own : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= 32'd0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_OWN_SERIAL) begin
            r_own <= pwdata;
        end
    end

    // hex digit decode
    always_comb begin
        w_is_hex = 1'b1;
        w_nib    = 4'd0;
        if (w_byte >= CH_0 && w_byte <= CH_9) begin
            w_nib = w_byte[3:0];
        end else if (w_byte >= CH_A && w_byte <= CH_F) begin
            w_nib = 4'(w_byte - LETTER_OFS);
        end else begin
            w_is_hex = 1'b0;
        end
    end

    // parser and sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_src     = r_src;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_err     = r_err;
        n_done    = r_done;
        n_res_acc = r_res_acc;
        n_res_idx = r_res_idx;
        n_res_ser = r_res_ser;
        w_launch  = 1'b0;
        w_load_out = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_mode == MODE_BYTE) begin
                    if (w_start) begin
                        n_pos  = 2'd1;
                        n_src  = SRC_OTHER;
                        n_acc  = 32'd0;
                        n_cnt  = '0;
                        n_err  = 1'b0;
                        n_done = 1'b0;
                    end else if (!r_done) begin
                        if (r_pos == 2'd1) begin
                            if (w_byte == CH_B) begin
                                n_src = SRC_BELL;
                            end else if (w_byte == CH_D) begin
                                n_src = SRC_DOOR;
                            end else begin
                                n_src = SRC_OTHER;
                            end
                            n_pos = 2'd2;
                        end else if (w_byte != CH_T) begin
                            if (!w_is_hex || r_cnt >= CNT_W'(MAX_DIGITS)) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc = {r_acc[27:0], w_nib};
                                n_cnt = r_cnt + 1'b1;
                            end
                        end else begin
                            n_done    = 1'b1;
                            n_pos     = 2'd0;
                            n_res_idx = 4'd0;
                            n_res_ser = 32'd0;
                            if (!r_err && r_src == SRC_DOOR) begin
                                w_launch = 1'b1;
                                n_state  = S_SEARCH;
                            end else begin
                                n_res_acc = !r_err && r_src == SRC_BELL && r_acc == r_own;
                                n_state   = S_SEND;
                            end
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (w_tok[LIST_DEPTH].valid) begin
                    n_res_acc = w_tok[LIST_DEPTH].hit;
                    n_res_idx = w_tok[LIST_DEPTH].hit ? w_tok[LIST_DEPTH].idx : 4'd0;
                    n_res_ser = w_tok[LIST_DEPTH].hit ? r_acc : 32'd0;
                    n_state   = S_SEND;
                end
            end
            S_SEND: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        if (w_load_out) begin
            n_m_valid = 1'b1;
            n_m_data  = '0;
            n_m_data[OD_ACC]              = r_res_acc;
            n_m_data[OD_SER_HI:OD_SER_LO] = r_acc;
            n_m_data[OD_IDX_HI:OD_IDX_LO] = r_res_idx;
            n_m_data[OD_MSR_HI:OD_MSR_LO] = r_res_ser;
            n_m_data[OD_ERR]              = r_err;
            n_m_user = r_src;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= 2'd0;
            r_src     <= SRC_OTHER;
            r_acc     <= 32'd0;
            r_cnt     <= '0;
            r_err     <= 1'b0;
            r_done    <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_src     <= n_src;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_err     <= n_err;
            r_done    <= n_done;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_acc <= n_res_acc;
        r_res_idx <= n_res_idx;
        r_res_ser <= n_res_ser;
        r_m_data  <= n_m_data;
        r_m_user  <= n_m_user;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // allow-list cell row
    assign w_tok[0] = '{valid: w_launch, done: 1'b0, hit: 1'b0, idx: 4'd0};

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic w_wsel;
        assign w_wsel = w_in_acc && w_mode == MODE_ENTRY && 32'(w_eidx) == g;

        hsff_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wsel),
            .i_wr_data (w_eval),
            .i_key     (r_acc),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

endmodule

FILE: sv/hsff_checker.sv
// Port-level checks of the frame filter, bound to the top level.
`include "hex_serial_frame_filter_macros.svh"

module hsff_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [hsff_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [hsff_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import hsff_pkg::*;

    `HSFF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `HSFF_ASSERT_SAME(a_err_rejects, m_axis_tvalid && m_axis_tdata[OD_ERR], !m_axis_tdata[OD_ACC])
    `HSFF_ASSERT_SAME(a_other_rejects, m_axis_tvalid && m_axis_tuser == SRC_OTHER, !m_axis_tdata[OD_ACC])
    `HSFF_ASSERT_SAME(a_match_zero, m_axis_tvalid && !(m_axis_tdata[OD_ACC] && m_axis_tuser == SRC_DOOR), m_axis_tdata[OD_MSR_HI:OD_IDX_LO] == '0)
    `HSFF_ASSERT_SAME(a_match_serial, m_axis_tvalid && m_axis_tdata[OD_ACC] && m_axis_tuser == SRC_DOOR, m_axis_tdata[OD_MSR_HI:OD_MSR_LO] == m_axis_tdata[OD_SER_HI:OD_SER_LO])

endmodule

bind hex_serial_frame_filter hsff_checker u_hsff_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
